### rtl/core/lidar_sector_obstacle_steering_core_assert.svh
// assertion macros for the lidar sector steering core
// used by the top level only; expects a clock named clk and a reset named rst
`ifndef LIDAR_SECTOR_OBSTACLE_STEERING_CORE_ASSERT_SVH
`define LIDAR_SECTOR_OBSTACLE_STEERING_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LSOS_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LSOS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### rtl/core/lsos_pkg.sv
// shared types, constants and helper functions of the lidar sector steering core
// no dependencies; used by every module of the core
`default_nettype none

package lsos_pkg;

  // slot store geometry
  localparam int SLOTS  = 20;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DIST_W = 16;
  localparam int SUM_W  = $clog2(SLOTS * 65535 + 1);
  localparam int HOT_W  = SUM_W + 1;
  localparam int SECTORS = 5;
  localparam int SEC_W  = $clog2(SECTORS + 1);
  localparam int SPAN_W = $clog2(SLOTS / SECTORS + 1);
  localparam int W_MIN  = 10;

  // register indexes
  localparam logic [1:0] CFG_SECURE  = 2'd0;
  localparam logic [1:0] CFG_HOTZONE = 2'd1;
  localparam logic [1:0] CFG_REVERSE = 2'd2;
  localparam logic [1:0] CFG_SCAN_W  = 2'd3;

  // register reset values
  localparam logic [DIST_W-1:0] SECURE_RST  = 16'd35;
  localparam logic [DIST_W-1:0] HOTZONE_RST = 16'd50;
  localparam logic [DIST_W-1:0] REVERSE_RST = 16'd10;
  localparam logic [4:0]        SCAN_W_RST  = 5'd20;

  // steering actions
  localparam logic [1:0] ACT_REVERSE = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_LEFT    = 2'd2;
  localparam logic [1:0] ACT_RIGHT   = 2'd3;

  // sector patterns that force reverse, and pattern masks
  localparam logic [4:0] PAT_REV_A  = 5'h17;
  localparam logic [4:0] PAT_REV_B  = 5'h15;
  localparam logic [4:0] PAT_REV_C  = 5'h1d;
  localparam logic [4:0] PAT_REV_D  = 5'h1f;
  localparam logic [4:0] MASK_MID   = 5'h0e;
  localparam logic [4:0] MASK_LEFT  = 5'h1c;
  localparam logic [4:0] MASK_RIGHT = 5'h07;

  // one classified sample
  typedef struct packed {
    logic [4:0]        slot;
    logic [DIST_W-1:0] distance;
    logic              slot_ok;
    logic              near;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic [DIST_W-1:0] clear_range;
    logic [DIST_W-1:0] crowd_limit;
    logic [DIST_W-1:0] reverse_distance;
    logic [4:0]        scan_width;
  } cfg_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // scan width saturated to the legal window
  function automatic logic [CNT_W-1:0] eff_width(input logic [4:0] sw);
    logic [CNT_W-1:0] w;
    w = CNT_W'(sw);
    if (sw < 5'(W_MIN)) w = CNT_W'(W_MIN);
    if ({1'b0, sw} > 6'(SLOTS)) w = CNT_W'(SLOTS);
    return w;
  endfunction

  // slots per sector, w / 5 by compare chain
  function automatic logic [SPAN_W-1:0] span_of(input logic [CNT_W-1:0] w);
    logic [SPAN_W-1:0] s;
    s = '0;
    for (int k = 1; k <= SLOTS / SECTORS; k++) begin
      if (w >= CNT_W'(SECTORS * k)) s = SPAN_W'(k);
    end
    return s;
  endfunction

  // steering decision from pattern and nearest distance
  function automatic logic [1:0] pick_action(input logic [4:0] p,
                                             input logic [DIST_W-1:0] nearest,
                                             input logic [DIST_W-1:0] rev);
    logic [1:0] a;
    if (p == PAT_REV_A || p == PAT_REV_B || p == PAT_REV_C || p == PAT_REV_D ||
        nearest <= rev) begin
      a = ACT_REVERSE;
    end else if ((p & MASK_MID) == 5'd0) begin
      a = ACT_FORWARD;
    end else if (((p & MASK_LEFT) >> 3) >= (p & MASK_RIGHT)) begin
      a = ACT_LEFT;
    end else begin
      a = ACT_RIGHT;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lsos_queue.sv
// two-entry item queue between the front and back parts
// depends on lsos_pkg
`default_nettype none

module lsos_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lsos_pkg::item_t push_item,
  input  wire logic            pop,
  output lsos_pkg::item_t      head,
  output lsos_pkg::q_stat_t    stat
);

  lsos_pkg::item_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

  assign head       = entry[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

endmodule

`default_nettype wire

### rtl/core/lsos_front.sv
// front part: accepts samples, classifies slot range and near flag, feeds the queue
// depends on lsos_pkg
`default_nettype none

module lsos_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [4:0]                   slot,
  input  wire logic [lsos_pkg::DIST_W-1:0]  distance,
  input  wire logic [lsos_pkg::DIST_W-1:0]  clear_range,
  input  wire lsos_pkg::q_stat_t            q_stat,
  output logic                              push,
  output lsos_pkg::item_t                   push_item
);

  logic            held;
  lsos_pkg::item_t item;
  logic            take;

  // hold an item only while the queue is full
  assign in_stall = held && q_stat.full;
  assign take     = in_valid && !in_stall;
  assign push     = held && !q_stat.full;
  assign push_item = item;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // classify the sample
  always_ff @(posedge clk) begin
    if (take) begin
      item.slot     <= slot;
      item.distance <= distance;
      item.slot_ok  <= ({1'b0, slot} < 6'(lsos_pkg::SLOTS));
      item.near     <= (distance < clear_range);
    end
  end

endmodule

`default_nettype wire

### rtl/core/lsos_back.sv
// back part: slot store, fill logic, window sweep and result register
// depends on lsos_pkg
`default_nettype none

module lsos_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lsos_pkg::cfg_t               cfg,
  input  wire lsos_pkg::q_stat_t            q_stat,
  input  wire lsos_pkg::item_t              head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [4:0]                        sector_pattern,
  output logic [lsos_pkg::DIST_W-1:0]       nearest,
  output logic                              crowded,
  output logic [1:0]                        action
);

  localparam int IDX_W  = lsos_pkg::IDX_W;
  localparam int CNT_W  = lsos_pkg::CNT_W;
  localparam int DIST_W = lsos_pkg::DIST_W;
  localparam int SUM_W  = lsos_pkg::SUM_W;
  localparam int HOT_W  = lsos_pkg::HOT_W;
  localparam int SEC_W  = lsos_pkg::SEC_W;
  localparam int SPAN_W = lsos_pkg::SPAN_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]        state;
  logic              running;
  logic [CNT_W-1:0]  fill_count;
  logic [DIST_W-1:0] range_store [lsos_pkg::SLOTS];
  logic [lsos_pkg::SLOTS-1:0] near_bits;

  logic [CNT_W-1:0]  sweep_idx;
  logic [DIST_W-1:0] min_acc;
  logic [SUM_W-1:0]  sum_acc;
  logic [SEC_W-1:0]  sec_idx;
  logic [SPAN_W-1:0] sec_pos;
  logic [SPAN_W-1:0] sec_cnt;
  logic [4:0]        pattern;

  // window geometry from the scan width
  logic [CNT_W-1:0]  win_w;
  logic [CNT_W-1:0]  skip;
  logic [CNT_W-1:0]  win_end;
  logic [CNT_W-1:0]  win_len;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] half;

  assign win_w   = lsos_pkg::eff_width(cfg.scan_width);
  assign skip    = (CNT_W'(lsos_pkg::SLOTS) - win_w) >> 1;
  assign win_end = CNT_W'(lsos_pkg::SLOTS) - skip;
  assign win_len = win_end - skip;
  assign span    = lsos_pkg::span_of(win_w);
  assign half    = span >> 1;

  // control decode
  logic start_fill;
  logic start_run;
  logic out_free;
  logic finish;

  assign pop        = (state == ST_IDLE) && !q_stat.empty;
  assign start_fill = pop && !running && (fill_count < win_len);
  assign start_run  = pop && !start_fill;
  assign out_free   = !out_valid || !out_stall;
  assign finish     = (state == ST_FINISH) && out_free;

  // one slot per sweep cycle
  logic [DIST_W-1:0] cur_dist;
  logic              cur_near;
  logic [SPAN_W-1:0] cnt_add;
  logic              sec_active;
  logic              sec_done;
  logic              sec_set;

  assign cur_dist   = range_store[sweep_idx[IDX_W-1:0]];
  assign cur_near   = near_bits[sweep_idx[IDX_W-1:0]];
  assign cnt_add    = sec_cnt + SPAN_W'(cur_near);
  assign sec_active = (sec_idx < SEC_W'(lsos_pkg::SECTORS));
  assign sec_done   = sec_active && (sec_pos == span - SPAN_W'(1));

  // outer sectors use any bit, inner ones need twice half the span
  always_comb begin
    if (sec_idx == SEC_W'(0) || sec_idx == SEC_W'(lsos_pkg::SECTORS - 1)) begin
      sec_set = (cnt_add != '0);
    end else begin
      sec_set = (half != '0) && ({1'b0, cnt_add} >= {half, 1'b0});
    end
  end

  // hot zone: sum / SLOTS <= limit, as sum < SLOTS * (limit + 1)
  logic hot_now;
  assign hot_now = HOT_W'(sum_acc) <
                   HOT_W'(lsos_pkg::SLOTS) * (HOT_W'(cfg.crowd_limit) + HOT_W'(1));

  // sequencer and sweep accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      running    <= 1'b0;
      fill_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start_fill) begin
            fill_count <= fill_count + CNT_W'(1);
          end else if (start_run) begin
            running <= 1'b1;
            state   <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (sweep_idx == win_end - CNT_W'(1)) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sweep datapath
  always_ff @(posedge clk) begin
    if (start_run) begin
      sweep_idx <= skip;
      min_acc   <= '1;
      sum_acc   <= '0;
      sec_idx   <= '0;
      sec_pos   <= '0;
      sec_cnt   <= '0;
      pattern   <= '0;
    end else if (state == ST_SWEEP) begin
      sweep_idx <= sweep_idx + CNT_W'(1);
      if (cur_dist < min_acc) min_acc <= cur_dist;
      sum_acc <= sum_acc + SUM_W'(cur_dist);
      if (sec_done) begin
        if (sec_set) pattern[3'(lsos_pkg::SECTORS - 1) - 3'(sec_idx)] <= 1'b1;
        sec_idx <= sec_idx + SEC_W'(1);
        sec_pos <= '0;
        sec_cnt <= '0;
      end else if (sec_active) begin
        sec_pos <= sec_pos + SPAN_W'(1);
        sec_cnt <= cnt_add;
      end
    end
  end

  // slot store and near bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lsos_pkg::SLOTS; i++) range_store[i] <= '0;
      near_bits <= '0;
    end else if (pop && head.slot_ok) begin
      range_store[head.slot[IDX_W-1:0]] <= head.distance;
      if (start_run) near_bits[head.slot[IDX_W-1:0]] <= head.near;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sector_pattern <= pattern;
      nearest        <= min_acc;
      crowded        <= hot_now;
      action         <= lsos_pkg::pick_action(pattern, min_acc, cfg.reverse_distance);
    end
  end

endmodule

`default_nettype wire

### rtl/core/lidar_sector_obstacle_steering_core.sv
// Lidar sector obstacle steering core, top level
// depends on lsos_pkg, lsos_front, lsos_queue, lsos_back and the assertion header
//
// Input channel (in_valid / in_stall, slot, distance): one lidar sample per item.
// Output channel (out_valid / out_stall, sector_pattern, nearest, crowded, action):
// one result per sample once the scan window has been filled.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high and a write takes effect at once. Write only while the core is idle.
// The first window-length samples after reset only fill the slot store and give
// no result. Every later sample gives one result.
// An accepted item is registered in the front stage and pushed into the queue;
// the back part pops it, sweeps the window (the window length is the effective
// scan width rounded up to even, one slot per cycle through the store) and then
// loads the result register, which raises out_valid.
// The back part takes no new item from the queue until the sweep of the last one
// has finished and its result is loaded; filling samples are taken without a sweep.
// Reset clears the slot store, the near bits, the fill count and the queue, and
// sets the registers to their defaults. A stalled result holds in the output
// register; the back part waits before loading the next one while the front
// stage and the two-entry queue keep taking samples until they are full.
`default_nettype none

module lidar_sector_obstacle_steering_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [4:0]                   slot,
  input  wire logic [lsos_pkg::DIST_W-1:0]  distance,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [4:0]                        sector_pattern,
  output logic [lsos_pkg::DIST_W-1:0]       nearest,
  output logic                              crowded,
  output logic [1:0]                        action,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [lsos_pkg::DIST_W-1:0]  cfg_data
);

  lsos_pkg::cfg_t    cfg;
  lsos_pkg::q_stat_t q_stat;
  lsos_pkg::item_t   push_item;
  lsos_pkg::item_t   head;
  logic              push;
  logic              pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clear_range      <= lsos_pkg::SECURE_RST;
      cfg.crowd_limit      <= lsos_pkg::HOTZONE_RST;
      cfg.reverse_distance <= lsos_pkg::REVERSE_RST;
      cfg.scan_width       <= lsos_pkg::SCAN_W_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsos_pkg::CFG_SECURE:  cfg.clear_range      <= cfg_data;
        lsos_pkg::CFG_HOTZONE: cfg.crowd_limit      <= cfg_data;
        lsos_pkg::CFG_REVERSE: cfg.reverse_distance <= cfg_data;
        lsos_pkg::CFG_SCAN_W:  cfg.scan_width       <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // front part
  lsos_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .slot        (slot),
    .distance    (distance),
    .clear_range (cfg.clear_range),
    .q_stat      (q_stat),
    .push        (push),
    .push_item   (push_item)
  );

  // queue between front and back
  lsos_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // back part
  lsos_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sector_pattern (sector_pattern),
    .nearest        (nearest),
    .crowded        (crowded),
    .action         (action)
  );

  // checks on front, queue and back cooperation
`include "lidar_sector_obstacle_steering_core_assert.svh"

  `LSOS_ASSERT_NOW(a_push_not_full, push, !q_stat.full, "item pushed into a full queue")
  `LSOS_ASSERT_NOW(a_pop_not_empty, pop, !q_stat.empty, "item popped from an empty queue")
  `LSOS_ASSERT_NOW(a_stall_only_full, in_stall, q_stat.full, "input stalled with queue room")

endmodule

`default_nettype wire

### sim/tb_lidar_sector_obstacle_steering_core.sv
// self-checking testbench for the lidar sector obstacle steering core
// depends on lsos_pkg and the core top level; drives samples, mirrors the scan
// store in its own predictor and checks every result item against it or a typed table value
`timescale 1ns / 1ps

module tb_lidar_sector_obstacle_steering_core;

  localparam int DIST_W        = lsos_pkg::DIST_W;
  localparam int SLOTS         = lsos_pkg::SLOTS;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 1030;

  // one result item as the core presents it
  typedef struct packed {
    logic [4:0]        pattern;
    logic [DIST_W-1:0] low;
    logic              hot;
    logic [1:0]        act;
  } steer_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {WANT_PREDICT, WANT_NONE, WANT_TYPED} want_t;

  // one line of the directed table
  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        reg_idx;
    logic [DIST_W-1:0] reg_val;
    logic [4:0]        slot;
    logic [DIST_W-1:0] reading;
    want_t             want;
    steer_t            typed;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [4:0]        slot = '0;
  logic [DIST_W-1:0] distance = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [4:0]        sector_pattern;
  logic [DIST_W-1:0] nearest;
  logic              crowded;
  logic [1:0]        action;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [DIST_W-1:0] cfg_data = '0;

  lidar_sector_obstacle_steering_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .slot           (slot),
    .distance       (distance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sector_pattern (sector_pattern),
    .nearest        (nearest),
    .crowded        (crowded),
    .action         (action),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the core's registers and scan store
  logic [DIST_W-1:0] m_secure  = lsos_pkg::SECURE_RST;
  logic [DIST_W-1:0] m_hotzone = lsos_pkg::HOTZONE_RST;
  logic [DIST_W-1:0] m_reverse = lsos_pkg::REVERSE_RST;
  logic [4:0]        m_scan_w  = lsos_pkg::SCAN_W_RST;
  logic [DIST_W-1:0] m_range [SLOTS];
  bit                m_near  [SLOTS];
  int                m_fill    = 0;
  bit                m_running = 1'b0;

  steer_t pending_steer [$];
  row_t   steer_rows [$];
  int     fail_count  = 0;
  int     cycle_count = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      m_range[i] = '0;
      m_near[i]  = 1'b0;
    end
  end

  // expected result of one sample, updating the mirrored state
  task automatic predict_steering(input logic [4:0] s, input logic [DIST_W-1:0] d,
                                  output bit got, output steer_t r);
    int w, skip, wend, span, half, cnt, base;
    int unsigned sum;
    logic [DIST_W-1:0] low;
    logic [4:0] pat;
    bit in_range, set;
    got = 1'b0;
    r = '0;
    w = int'(m_scan_w);
    if (w < lsos_pkg::W_MIN) w = lsos_pkg::W_MIN;
    if (w > SLOTS) w = SLOTS;
    skip = (SLOTS - w) / 2;
    wend = SLOTS - skip;
    span = w / 5;
    half = span / 2;
    in_range = int'(s) < SLOTS;
    if (in_range) m_range[s] = d;
    // still filling the window: no result
    if (!m_running && m_fill < wend - skip) begin
      m_fill++;
    end else begin
      m_running = 1'b1;
      got = 1'b1;
      low = m_range[skip];
      sum = 0;
      for (int i = skip; i < wend; i++) begin
        if (m_range[i] < low) low = m_range[i];
        sum += m_range[i];
      end
      if (in_range) m_near[s] = d < m_secure;
      // outer sectors on any bit, inner ones on the count rule
      pat = '0;
      for (int k = 0; k < 5; k++) begin
        base = skip + k * span;
        cnt = 0;
        for (int i = 0; i < span; i++) cnt += m_near[base + i];
        if (k == 0 || k == 4) set = cnt != 0;
        else set = half != 0 && (cnt / half) > 1;
        if (set) pat[4 - k] = 1'b1;
      end
      r.pattern = pat;
      r.low = low;
      r.hot = (sum / SLOTS) <= m_hotzone;
      if (pat == lsos_pkg::PAT_REV_A || pat == lsos_pkg::PAT_REV_B ||
          pat == lsos_pkg::PAT_REV_C || pat == lsos_pkg::PAT_REV_D ||
          low <= m_reverse) begin
        r.act = lsos_pkg::ACT_REVERSE;
      end else if ((pat & lsos_pkg::MASK_MID) == 5'd0) begin
        r.act = lsos_pkg::ACT_FORWARD;
      end else if (((pat & lsos_pkg::MASK_LEFT) >> 3) >= (pat & lsos_pkg::MASK_RIGHT)) begin
        r.act = lsos_pkg::ACT_LEFT;
      end else begin
        r.act = lsos_pkg::ACT_RIGHT;
      end
    end
  endtask

  // present one sample and hold it until taken
  task automatic send_sample(input logic [4:0] s, input logic [DIST_W-1:0] d,
                             input want_t want, input steer_t typed);
    bit got;
    steer_t r;
    @(negedge clk);
    cfg_valid = 1'b0;
    in_valid = 1'b1;
    slot = s;
    distance = d;
    do @(posedge clk); while (in_stall);
    predict_steering(s, d, got, r);
    if (want == WANT_TYPED) pending_steer.push_back(typed);
    else if (want == WANT_PREDICT && got) pending_steer.push_back(r);
  endtask

  // register write, only issued while the core is idle
  task automatic write_reg(input logic [1:0] idx, input logic [DIST_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lsos_pkg::CFG_SECURE:  m_secure = val;
      lsos_pkg::CFG_HOTZONE: m_hotzone = val;
      lsos_pkg::CFG_REVERSE: m_reverse = val;
      lsos_pkg::CFG_SCAN_W:  m_scan_w = val[4:0];
      default: ;
    endcase
  endtask

  // wait for every outstanding result, then let filling items still queued be taken
  task automatic drain_results;
    @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_item(input logic [4:0] s, input logic [DIST_W-1:0] d,
                          input want_t want, input steer_t typed);
    row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.slot = s;
    row.reading = d;
    row.want = want;
    row.typed = typed;
    steer_rows.push_back(row);
  endtask

  task automatic put_cfg(input logic [1:0] idx, input logic [DIST_W-1:0] val);
    row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    steer_rows.push_back(row);
  endtask

  // register value: mostly moderate, sometimes an extreme
  function automatic logic [DIST_W-1:0] pick_level(input int typical);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return DIST_W'($urandom_range(0, typical));
    endcase
  endfunction

  // sample distance, biased around the thresholds of the current settings
  function automatic logic [DIST_W-1:0] pick_distance(input int near_pct);
    int sec, hi;
    sec = int'(m_secure);
    if ($urandom_range(0, 99) < near_pct && sec != 0) return DIST_W'($urandom_range(0, sec - 1));
    case ($urandom_range(0, 5))
      0: return DIST_W'($urandom);
      1: begin
        hi = int'(m_reverse) + 20;
        if (hi > 65535) hi = 65535;
        return DIST_W'($urandom_range(0, hi));
      end
      2: return $urandom_range(0, 1) ? '1 : '0;
      3: return (sec == 0) ? '0 : DIST_W'(sec - int'($urandom_range(0, 1)));
      4: begin
        hi = 2 * sec + 10;
        if (hi > 65535) hi = 65535;
        return DIST_W'($urandom_range(sec, hi));
      end
      default: return DIST_W'($urandom_range(0, 400));
    endcase
  endfunction

  // receiver: stall pattern switching between free running, random and long runs
  int stall_mode = 0;
  int mode_left  = 0;
  int run_left   = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = $urandom_range(0, 1);
      default: begin
        if (run_left == 0) begin
          out_stall = ~out_stall;
          run_left = $urandom_range(1, 30);
        end else begin
          run_left--;
        end
      end
    endcase
  end

  // result checking against the oldest expectation
  steer_t seen, wanted;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = {sector_pattern, nearest, crowded, action};
      if (pending_steer.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result item: pattern %h nearest %0d hot %b action %0d",
                   seen.pattern, seen.low, seen.hot, seen.act);
      end else begin
        wanted = pending_steer.pop_front();
        if (seen.pattern !== wanted.pattern || seen.low !== wanted.low ||
            seen.hot !== wanted.hot || seen.act !== wanted.act) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: pattern %h/%h nearest %0d/%0d hot %b/%b action %0d/%0d (exp/act)",
                     wanted.pattern, seen.pattern, wanted.low, seen.low,
                     wanted.hot, seen.hot, wanted.act, seen.act);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL lidar_sector_obstacle_steering_core");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    bit prev_item;
    int sent, phase_len, phase_sent, burst, gap, near_pct, cursor;
    bit sweep;
    logic [4:0] s;

    // directed table: extremes first, filling then a narrower window taking over
    put_cfg(lsos_pkg::CFG_SECURE, '0);
    put_cfg(lsos_pkg::CFG_HOTZONE, '1);
    put_cfg(lsos_pkg::CFG_REVERSE, '1);
    put_cfg(lsos_pkg::CFG_SCAN_W, 16'd31);
    for (int i = 5; i < 15; i++) put_item(5'(i), '1, WANT_NONE, '0);
    put_item(5'd31, '0, WANT_NONE, '0);
    put_item(5'd20, '0, WANT_NONE, '0);
    // width below range saturates to 10: fill count already past it
    put_cfg(lsos_pkg::CFG_SCAN_W, '0);
    put_item(5'd5, '1, WANT_TYPED, {5'd0, 16'hFFFF, 1'b1, lsos_pkg::ACT_REVERSE});
    put_item(5'd9, '0, WANT_TYPED, {5'd0, 16'd0, 1'b1, lsos_pkg::ACT_REVERSE});
    // full window, every slot obstructed unless at the maximum
    put_cfg(lsos_pkg::CFG_SECURE, '1);
    put_cfg(lsos_pkg::CFG_HOTZONE, '0);
    put_cfg(lsos_pkg::CFG_REVERSE, '0);
    put_cfg(lsos_pkg::CFG_SCAN_W, 16'd20);
    put_item(5'd0, '0, WANT_PREDICT, '0);
    put_item(5'd1, '0, WANT_PREDICT, '0);
    put_item(5'd2, 16'd1, WANT_PREDICT, '0);
    put_item(5'd3, 16'd2, WANT_PREDICT, '0);
    for (int i = 4; i < 8; i++) put_item(5'(i), '0, WANT_PREDICT, '0);
    put_item(5'd31, 16'h8000, WANT_PREDICT, '0);
    put_item(5'd19, '1, WANT_PREDICT, '0);
    put_item(5'd16, 16'hFFFE, WANT_PREDICT, '0);
    // mid settings, sample outside the window
    put_cfg(lsos_pkg::CFG_SECURE, 16'd1000);
    put_cfg(lsos_pkg::CFG_HOTZONE, 16'd20000);
    put_cfg(lsos_pkg::CFG_REVERSE, 16'd100);
    put_cfg(lsos_pkg::CFG_SCAN_W, 16'd15);
    put_item(5'd18, 16'd500, WANT_PREDICT, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // walk the directed table
    prev_item = 1'b0;
    foreach (steer_rows[i]) begin
      if (steer_rows[i].kind == ROW_CFG) begin
        if (prev_item) drain_results();
        write_reg(steer_rows[i].reg_idx, steer_rows[i].reg_val);
        prev_item = 1'b0;
      end else begin
        send_sample(steer_rows[i].slot, steer_rows[i].reading, steer_rows[i].want,
                    steer_rows[i].typed);
        prev_item = 1'b1;
      end
    end

    // random phases, each under fresh settings
    sent = 0;
    cursor = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      write_reg(lsos_pkg::CFG_SECURE, pick_level(2000));
      write_reg(lsos_pkg::CFG_HOTZONE, pick_level(3000));
      write_reg(lsos_pkg::CFG_REVERSE, pick_level(200));
      case ($urandom_range(0, 5))
        0: write_reg(lsos_pkg::CFG_SCAN_W, 16'd10);
        1: write_reg(lsos_pkg::CFG_SCAN_W, 16'd20);
        2: write_reg(lsos_pkg::CFG_SCAN_W, DIST_W'($urandom_range(0, 9)));
        3: write_reg(lsos_pkg::CFG_SCAN_W, DIST_W'($urandom_range(21, 31)));
        default: write_reg(lsos_pkg::CFG_SCAN_W, DIST_W'($urandom_range(10, 20)));
      endcase
      near_pct = $urandom_range(10, 90);
      phase_len = $urandom_range(60, 140);
      phase_sent = 0;
      while (phase_sent < phase_len && sent < RANDOM_ITEMS) begin
        burst = $urandom_range(1, 24);
        sweep = $urandom_range(0, 9) < 6;
        for (int b = 0; b < burst; b++) begin
          // now and then an out-of-range slot; servo sweeps in slot order, otherwise scattered slots
          if ($urandom_range(0, 9) == 0) begin
            s = 5'($urandom_range(SLOTS, 31));
          end else if (sweep) begin
            s = 5'(cursor);
            cursor = (cursor + 1) % SLOTS;
          end else begin
            s = 5'($urandom_range(0, SLOTS - 1));
          end
          send_sample(s, pick_distance(near_pct), WANT_PREDICT, '0);
          phase_sent++;
          sent++;
        end
        // occasionally hold off until the core has emptied, otherwise mostly pause the input for a random gap
        if ($urandom_range(0, 19) == 0) begin
          drain_results();
        end else if ($urandom_range(0, 3) != 0) begin
          gap = $urandom_range(1, 40);
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("PASS lidar_sector_obstacle_steering_core");
    end else begin
      $display("FAIL lidar_sector_obstacle_steering_core");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lsos_pkg.sv
rtl/core/lsos_queue.sv
rtl/core/lsos_front.sv
rtl/core/lsos_back.sv
rtl/core/lidar_sector_obstacle_steering_core.sv
sim/tb_lidar_sector_obstacle_steering_core.sv
